// ===== sv/occluded_span_culler_top_defines.svh =====
// Assertion macros for the occluded span culler.
// Used by occluded_span_culler_top; expects clk and arst_n in the including scope.
`ifndef OCCLUDED_SPAN_CULLER_TOP_DEFINES_SVH
`define OCCLUDED_SPAN_CULLER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define OSC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define OSC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define OSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/osc_pkg.sv =====
// Shared types and constants for the occluded span culler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package osc_pkg;

	localparam int ID_W               = 16;
	localparam int ROW_W              = 16;
	localparam int VSTART_W           = ROW_W + 1;
	localparam int DEFAULT_LIST_DEPTH = 16;

	// Operation carried by an input beat.
	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_FLUSH = 1'b1
	} span_op_t;

	// One list entry: the still-visible part of a rectangle.
	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [VSTART_W-1:0] vstart;
		logic [ROW_W-1:0]    end_row;
		logic [ROW_W-1:0]    right_edge;
	} entry_t;

	// Verdict of the compare unit on one entry.
	typedef struct packed {
		logic   drop;
		logic   hidden;
		logic   trim_done;
		entry_t kept;
	} verdict_t;

	// A request to emit one result beat.
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
		logic            hidden;
	} emit_req_t;

endpackage

// ===== sv/osc_item_if.sv =====
// Input channel of the occluded span culler: valid, ready and one rectangle or flush.
// Depends on osc_pkg for field widths.
`timescale 1ns / 1ps

interface osc_item_if
	import osc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             func;
	logic [ID_W-1:0]  feature_id;
	logic [ROW_W-1:0] start_row;
	logic [ROW_W-1:0] end_row;
	logic [ROW_W-1:0] right_edge;

	modport source (
		output valid, func, feature_id, start_row, end_row, right_edge,
		input  ready
	);
	modport sink (
		input  valid, func, feature_id, start_row, end_row, right_edge,
		output ready
	);
endinterface

// ===== sv/osc_result_if.sv =====
// Output channel of the occluded span culler: valid, ready and one retired entry.
// Depends on osc_pkg for field widths.
`timescale 1ns / 1ps

interface osc_result_if
	import osc_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] retired_id;
	logic            hidden;
	logic            last_of_run;

	modport source (
		output valid, retired_id, hidden, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, retired_id, hidden, last_of_run,
		output ready
	);
endinterface

// ===== sv/osc_span_mem.sv =====
// Entry store of the occluded span culler: one write port, one registered read port.
// Depends on osc_pkg for the entry type.
`timescale 1ns / 1ps

module osc_span_mem
	import osc_pkg::*;
#(
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data
);
	localparam int MEM_DEPTH = 1 << ADDR_W;

	entry_t mem_q [MEM_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// ===== sv/osc_cover_unit.sv =====
// Shared compare unit: judges one stored entry against the current rectangle.
// Depends on osc_pkg for the entry and verdict types.
`timescale 1ns / 1ps

module osc_cover_unit
	import osc_pkg::*;
(
	input  entry_t           entry,
	input  logic             flush,
	input  logic             trimming,
	input  logic [ROW_W-1:0] start_row,
	input  logic [ROW_W-1:0] end_row,
	input  logic [ROW_W-1:0] right_edge,
	output verdict_t         verdict
);
	logic [VSTART_W-1:0] raised;
	logic [VSTART_W-1:0] new_vstart;
	logic                covered;

	always_comb begin
		raised     = {1'b0, end_row} + VSTART_W'(1);
		covered    = right_edge >= entry.right_edge;
		new_vstart = (raised > entry.vstart) ? raised : entry.vstart;

		verdict           = '0;
		verdict.kept      = entry;
		verdict.trim_done = 1'b1;
		if (flush) begin
			verdict.drop = 1'b1;
		end else if (trimming && (entry.vstart < {1'b0, start_row})) begin
			// Head entry whose visible part starts before the new rectangle's start row.
			verdict.drop      = 1'b1;
			verdict.trim_done = 1'b0;
		end else if (covered) begin
			verdict.kept.vstart = new_vstart;
			if (new_vstart > {1'b0, entry.end_row}) begin
				verdict.drop   = 1'b1;
				verdict.hidden = 1'b1;
			end
		end
	end
endmodule

// ===== sv/osc_result_stage.sv =====
// Result stage: holds one pending result back until its successor or the end of the run
// is known, so that last_of_run can be set, and drives the output register. Uses osc_pkg.
`timescale 1ns / 1ps

module osc_result_stage
	import osc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  emit_req_t req,
	input  logic      close,
	output logic      req_taken,
	output logic      closed,
	output logic      pend_busy,
	osc_result_if.source results
);
	logic            out_valid_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_hidden_q;
	logic            out_last_q;
	logic            pend_valid_q;
	logic [ID_W-1:0] pend_id_q;
	logic            pend_hidden_q;
	logic            out_free;
	logic            load_mid;
	logic            load_last;

	assign out_free  = !out_valid_q || results.ready;
	assign req_taken = !pend_valid_q || out_free;
	assign closed    = !pend_valid_q || out_free;
	assign pend_busy = pend_valid_q;

	// The pending result moves on either because a newer one arrives or because the run ends.
	assign load_mid  = req.valid && pend_valid_q && out_free;
	assign load_last = !req.valid && close && pend_valid_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (load_mid || load_last) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (req.valid && req_taken) begin
				pend_valid_q <= 1'b1;
			end else if (load_last) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_mid) begin
			out_id_q     <= pend_id_q;
			out_hidden_q <= pend_hidden_q;
			out_last_q   <= 1'b0;
		end else if (load_last) begin
			out_id_q     <= pend_id_q;
			out_hidden_q <= pend_hidden_q;
			out_last_q   <= 1'b1;
		end
		if (req.valid && req_taken) begin
			pend_id_q     <= req.id;
			pend_hidden_q <= req.hidden;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.retired_id  = out_id_q;
	assign results.hidden      = out_hidden_q;
	assign results.last_of_run = out_last_q;
endmodule

// ===== sv/occluded_span_culler_top.sv =====
// Top level of the occluded span culler: sequencer, entry store, compare unit, result stage.
// Depends on osc_pkg, osc_item_if, osc_result_if, osc_span_mem, osc_cover_unit,
// osc_result_stage and occluded_span_culler_top_defines.svh.
`timescale 1ns / 1ps
`include "occluded_span_culler_top_defines.svh"

// Usage
// The items channel takes one beat per rectangle (func = 0) or flush (func = 1); rectangles
// must come in non-decreasing start_row order. The results channel gives one beat for each
// entry that leaves the list, oldest first within its kind, with last_of_run set on the final
// beat caused by an item. An item that retires nothing gives no beat at all.
// The list lives in a small circular memory with a registered read port. A sequencer walks
// the stored entries one per cycle, unless the result stage stalls, through a single compare
// unit, which trims, covers and drops them, and writes the survivors back in compacted order.
// After an accept the sequencer steps through PRIME, which fills the read register, WALK,
// which judges the stored entries, END, which writes the new rectangle or empties the list
// on a flush, and FINAL, and then returns to IDLE. The final result beat is loaded in FINAL.
// Items are not accepted while one is being worked on.
// Results wait one step in a pending register, so that the last one of a run can be told
// apart. When the receiver stalls the output register holds its beat; once the pending
// register is full as well, the walk halts on its next entry, whether or not that entry
// retires, until the beat has been taken.
// After reset the list is empty and the block is ready at once; the memory needs no clearing,
// as only entries below the fill count are ever read.
module occluded_span_culler_top
	import osc_pkg::*;
#(
	parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	osc_item_if.sink     items,
	osc_result_if.source results
);
	localparam int ADDR_W  = $clog2(LIST_DEPTH);
	localparam int COUNT_W = $clog2(LIST_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_END   = 3'd3;
	localparam logic [2:0] ST_FINAL = 3'd4;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  head_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] rd_idx_q;
	logic [COUNT_W-1:0] wr_idx_q;
	logic               trimming_q;
	logic [ID_W-1:0]    first_id_q;

	// Latched item.
	logic               func_q;
	logic [ID_W-1:0]    feature_id_q;
	logic [ROW_W-1:0]   start_row_q;
	logic [ROW_W-1:0]   end_row_q;
	logic [ROW_W-1:0]   right_edge_q;

	entry_t             rd_entry;
	entry_t             wr_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	verdict_t           verdict;
	emit_req_t          req;
	logic               req_taken;
	logic               close;
	logic               closed;
	logic               pend_busy;
	logic               walking;
	logic               step;
	logic               list_full;
	logic               is_flush;

	// Walking means an entry is in the read register and still to be judged.
	assign walking   = (state_q == ST_WALK) && (rd_idx_q != count_q);
	assign step      = walking && req_taken;
	assign list_full = wr_idx_q == COUNT_W'(LIST_DEPTH);
	assign is_flush  = func_q == OP_FLUSH;

	assign items.ready = state_q == ST_IDLE;

	// Read one ahead while advancing, so that the next entry is ready in the following cycle.
	assign rd_addr = head_q + rd_idx_q[ADDR_W-1:0] + ADDR_W'(step);

	always_comb begin
		req     = '0;
		wr_en   = 1'b0;
		wr_addr = head_q + wr_idx_q[ADDR_W-1:0];
		wr_data = verdict.kept;
		close   = state_q == ST_FINAL;
		if (walking) begin
			req.valid  = verdict.drop;
			req.id     = rd_entry.id;
			req.hidden = verdict.hidden;
			wr_en      = step && !verdict.drop;
		end else if ((state_q == ST_END) && !is_flush) begin
			// The oldest survivor goes out as visible when the list would overflow; the new
			// rectangle lands behind the survivors, which is also the oldest one's slot if so.
			req.valid         = list_full;
			req.id            = first_id_q;
			req.hidden        = 1'b0;
			wr_en             = req_taken;
			wr_data.id        = feature_id_q;
			wr_data.vstart    = {1'b0, start_row_q};
			wr_data.end_row   = end_row_q;
			wr_data.right_edge = right_edge_q;
		end
	end

	osc_span_mem #(
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	osc_cover_unit u_cover (
		.entry      (rd_entry),
		.flush      (is_flush),
		.trimming   (trimming_q),
		.start_row  (start_row_q),
		.end_row    (end_row_q),
		.right_edge (right_edge_q),
		.verdict    (verdict)
	);

	osc_result_stage u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.close     (close),
		.req_taken (req_taken),
		.closed    (closed),
		.pend_busy (pend_busy),
		.results   (results)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			rd_idx_q   <= '0;
			wr_idx_q   <= '0;
			trimming_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (items.valid) begin
						rd_idx_q   <= '0;
						wr_idx_q   <= '0;
						trimming_q <= 1'b1;
						state_q    <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (!walking) begin
						state_q <= ST_END;
					end else if (step) begin
						rd_idx_q <= rd_idx_q + COUNT_W'(1);
						if (!verdict.drop) begin
							wr_idx_q <= wr_idx_q + COUNT_W'(1);
						end
						if (verdict.trim_done) begin
							trimming_q <= 1'b0;
						end
					end
				end
				ST_END: begin
					if (is_flush) begin
						count_q <= '0;
						state_q <= ST_FINAL;
					end else if (req_taken) begin
						if (list_full) begin
							head_q  <= head_q + ADDR_W'(1);
							count_q <= COUNT_W'(LIST_DEPTH);
						end else begin
							count_q <= wr_idx_q + COUNT_W'(1);
						end
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (closed) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			func_q       <= items.func;
			feature_id_q <= items.feature_id;
			start_row_q  <= items.start_row;
			end_row_q    <= items.end_row;
			right_edge_q <= items.right_edge;
		end
		if (step && !verdict.drop && (wr_idx_q == '0)) begin
			first_id_q <= rd_entry.id;
		end
	end

	// Checks on the sequencer and the result hand-off.
	`OSC_ASSERT_ALWAYS(a_count_bound, count_q <= COUNT_W'(LIST_DEPTH), "list count above depth")
	`OSC_ASSERT_IMPLIES(a_compact_order, state_q == ST_WALK, wr_idx_q <= rd_idx_q,
		"write index ran ahead of read index")
	`OSC_ASSERT_IMPLIES(a_ready_clean, items.ready, !pend_busy,
		"ready with a result of the previous item still pending")
	`OSC_ASSERT_NEXT(a_accept_prime, items.valid && items.ready, state_q == ST_PRIME,
		"accepted item did not start the walk")
endmodule
